@@ src/length_prefixed_frame_receiver_core_defines.svh @@
// assertion macros for the length-prefixed frame receiver
// included by the top level; no other dependencies
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTH

`define LPFR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define LPFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LPFR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define LPFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/lpfr_pkg.sv @@
// shared types and constants for the length-prefixed frame receiver
// no dependencies
`timescale 1ns / 1ps

package lpfr_pkg;

   localparam int HEADER_BYTES = 16;
   localparam int HDR_POS_W    = $clog2(HEADER_BYTES);

   // header byte positions of the two big-endian lengths
   localparam int META_LEN_FIRST = 4;
   localparam int MSG_LEN_FIRST  = 8;
   localparam int LEN_END        = 12;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 32;
   localparam int LEN_W    = 32;

   typedef enum logic [1:0] {
      SEC_HEADER  = 2'd0,
      SEC_META    = 2'd1,
      SEC_MESSAGE = 2'd2,
      SEC_DISCARD = 2'd3
   } section_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data;
      section_type         section;
      logic [OFFSET_W-1:0] offset;
      logic                done;
      logic                err;
   } lpfr_result_type;

endpackage

@@ src/length_prefixed_frame_receiver_core.sv @@
// Length-prefixed frame receiver, top level.
// Input channel: one byte beat per transfer on req_data_byte (req_valid / req_stall).
// Each frame is a 16-byte header, then meta bytes, then message bytes; header
// bytes 4-7 and 8-11 carry the big-endian meta and message lengths.
// Result channel: one beat per input byte on rsp_* with the byte, its section,
// its offset in that section, a frame-complete flag and an oversize error flag.
// csr_write_enable / csr_write_data load the size limit; write only when idle.
// Path: each byte passes through the input register, then the result register,
// where it waits until taken. Throughput: 1 byte per cycle while rsp_stall is
// low; the frame position counters update once for each byte that moves on.
// An oversize body (meta + message at or above the limit) flags the last header
// byte; every later byte is tagged discarded until reset.
// Reset (synchronous, active high) empties both registers, returns to the start
// of a header and sets the size limit to all ones.
// When rsp_stall is high the result register holds; one more byte is taken into
// the input register, after which req_stall follows rsp_stall.
// depends on lpfr_pkg, lpfr_ingress, lpfr_tracker, lpfr_egress
`timescale 1ns / 1ps
`include "length_prefixed_frame_receiver_core_defines.svh"

module length_prefixed_frame_receiver_core
   import lpfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_byte_out,
   output logic [1:0]          rsp_section,
   output logic [OFFSET_W-1:0] rsp_offset,
   output logic                rsp_frame_done,
   output logic                rsp_error_code,
   input  logic                csr_write_enable,
   input  logic [LEN_W-1:0]    csr_write_data
);

   logic              advance;
   logic              stage_valid;
   logic [BYTE_W-1:0] stage_data;
   lpfr_result_type   result;
   lpfr_result_type   rsp_result;
   logic [LEN_W-1:0]  body_limit_ff, body_limit_in;

   assign body_limit_in = csr_write_enable ? csr_write_data : body_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_limit_ff <= '1;
      end else begin
         body_limit_ff <= body_limit_in;
      end
   end

   lpfr_ingress u_ingress (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .stage_valid   (stage_valid),
      .stage_data    (stage_data)
   );

   lpfr_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data       (stage_data),
      .body_limit (body_limit_ff),
      .result     (result)
   );

   lpfr_egress u_egress (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_byte_out   = rsp_result.data;
   assign rsp_section    = rsp_result.section;
   assign rsp_offset     = rsp_result.offset;
   assign rsp_frame_done = rsp_result.done;
   assign rsp_error_code = rsp_result.err;

   `LPFR_ASSERT_SAME(a_done_err_excl, clock, reset, rsp_valid, !(rsp_frame_done && rsp_error_code), "frame done together with error")
   `LPFR_ASSERT_SAME(a_discard_err, clock, reset, rsp_valid && (rsp_section == SEC_DISCARD), rsp_error_code && (rsp_offset == '0), "discarded beat without error")
   `LPFR_ASSERT_SAME(a_stall_needs_stage, clock, reset, !stage_valid, !req_stall, "input stalled with empty stage")
   `LPFR_ASSERT_NEXT(a_err_sticky, clock, reset, advance && (result.err == 1'b1), result.err == 1'b1, "error not sticky")

endmodule

@@ src/lpfr_ingress.sv @@
// input register stage: captures one byte beat and holds it until it moves on
// depends on lpfr_pkg
`timescale 1ns / 1ps

module lpfr_ingress
   import lpfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              advance,
   output logic              stage_valid,
   output logic [BYTE_W-1:0] stage_data
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

@@ src/lpfr_tracker.sv @@
// frame position tracking: header decode, length capture, section tagging
// depends on lpfr_pkg
`timescale 1ns / 1ps

module lpfr_tracker
   import lpfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] data,
   input  logic [LEN_W-1:0]  body_limit,
   output lpfr_result_type   result
);

   section_type            phase_ff, phase_in;
   logic [HDR_POS_W-1:0]   hdr_pos_ff, hdr_pos_in;
   logic [OFFSET_W-1:0]    sec_off_ff, sec_off_in;
   logic [LEN_W-1:0]       meta_len_ff, meta_len_in;
   logic [LEN_W-1:0]       msg_len_ff, msg_len_in;
   logic [LEN_W:0]         body;
   logic [OFFSET_W-1:0]    sec_off_inc;

   assign sec_off_inc = sec_off_ff + OFFSET_W'(1);
   assign body        = {1'b0, meta_len_in} + {1'b0, msg_len_in};

   always_comb begin
      phase_in    = phase_ff;
      hdr_pos_in  = hdr_pos_ff;
      sec_off_in  = sec_off_ff;
      meta_len_in = meta_len_ff;
      msg_len_in  = msg_len_ff;
      result.data    = data;
      result.section = phase_ff;
      result.offset  = '0;
      result.done    = 1'b0;
      result.err     = 1'b0;
      unique case (phase_ff)
         SEC_HEADER: begin
            result.offset = OFFSET_W'(hdr_pos_ff);
            if (hdr_pos_ff >= HDR_POS_W'(META_LEN_FIRST)
                  && hdr_pos_ff < HDR_POS_W'(MSG_LEN_FIRST)) begin
               meta_len_in = {meta_len_ff[LEN_W-BYTE_W-1:0], data};
            end else if (hdr_pos_ff >= HDR_POS_W'(MSG_LEN_FIRST)
                  && hdr_pos_ff < HDR_POS_W'(LEN_END)) begin
               msg_len_in = {msg_len_ff[LEN_W-BYTE_W-1:0], data};
            end
            if (hdr_pos_ff == HDR_POS_W'(HEADER_BYTES - 1)) begin
               hdr_pos_in = '0;
               sec_off_in = '0;
               priority if (body >= {1'b0, body_limit}) begin
                  result.err = 1'b1;
                  phase_in   = SEC_DISCARD;
               end else if (body == '0) begin
                  result.done = 1'b1;
               end else if (meta_len_in != '0) begin
                  phase_in = SEC_META;
               end else begin
                  phase_in = SEC_MESSAGE;
               end
            end else begin
               hdr_pos_in = hdr_pos_ff + HDR_POS_W'(1);
            end
         end
         SEC_META: begin
            result.offset = sec_off_ff;
            if (sec_off_inc == meta_len_ff) begin
               sec_off_in = '0;
               if (msg_len_ff == '0) begin
                  result.done = 1'b1;
                  phase_in    = SEC_HEADER;
               end else begin
                  phase_in = SEC_MESSAGE;
               end
            end else begin
               sec_off_in = sec_off_inc;
            end
         end
         SEC_MESSAGE: begin
            result.offset = sec_off_ff;
            if (sec_off_inc == msg_len_ff) begin
               result.done = 1'b1;
               phase_in    = SEC_HEADER;
               sec_off_in  = '0;
            end else begin
               sec_off_in = sec_off_inc;
            end
         end
         SEC_DISCARD: begin
            result.err = 1'b1;
         end
         default: begin
            result.err = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= SEC_HEADER;
         hdr_pos_ff  <= '0;
         sec_off_ff  <= '0;
         meta_len_ff <= '0;
         msg_len_ff  <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         hdr_pos_ff  <= hdr_pos_in;
         sec_off_ff  <= sec_off_in;
         meta_len_ff <= meta_len_in;
         msg_len_ff  <= msg_len_in;
      end
   end

endmodule

@@ src/lpfr_egress.sv @@
// result register: holds one tagged byte beat until the consumer takes it
// depends on lpfr_pkg
`timescale 1ns / 1ps

module lpfr_egress
   import lpfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            stage_valid,
   input  lpfr_result_type result,
   output logic            advance,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output lpfr_result_type rsp_result
);

   logic            valid_ff, valid_in;
   lpfr_result_type result_ff, result_in;

   assign advance = stage_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in  = valid_ff && rsp_stall;
      result_in = result_ff;
      if (advance) begin
         valid_in  = 1'b1;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ verif/length_prefixed_frame_receiver_core_test.sv @@
// self-checking bench for the length-prefixed frame receiver: typed header beats,
// random frames under several size limits, then a zero-limit oversize tail
// depends on lpfr_pkg and length_prefixed_frame_receiver_core
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_core_test;
   import lpfr_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_byte_out;
   logic [1:0]          rsp_section;
   logic [OFFSET_W-1:0] rsp_offset;
   logic                rsp_frame_done;
   logic                rsp_error_code;
   logic                csr_write_enable = 1'b0;
   logic [LEN_W-1:0]    csr_write_data = '0;

   length_prefixed_frame_receiver_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_section      (rsp_section),
      .rsp_offset       (rsp_offset),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_error_code   (rsp_error_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rows 0-15: empty frame after reset; rows 16-34: zero limit, maximum lengths, discards
   lpfr_result_type beat_table [0:34] = '{
      '{8'hFF, SEC_HEADER,  32'd0,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd1,  1'b0, 1'b0},
      '{8'hA5, SEC_HEADER,  32'd2,  1'b0, 1'b0},
      '{8'h5A, SEC_HEADER,  32'd3,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd4,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd5,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd6,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd7,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd8,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd9,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd10, 1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd11, 1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd12, 1'b0, 1'b0},
      '{8'h80, SEC_HEADER,  32'd13, 1'b0, 1'b0},
      '{8'h01, SEC_HEADER,  32'd14, 1'b0, 1'b0},
      '{8'h7F, SEC_HEADER,  32'd15, 1'b1, 1'b0},
      '{8'h00, SEC_HEADER,  32'd0,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd1,  1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd2,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd3,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd4,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd5,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd6,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd7,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd8,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd9,  1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd10, 1'b0, 1'b0},
      '{8'hFF, SEC_HEADER,  32'd11, 1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd12, 1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd13, 1'b0, 1'b0},
      '{8'h00, SEC_HEADER,  32'd14, 1'b0, 1'b0},
      '{8'h55, SEC_HEADER,  32'd15, 1'b0, 1'b1},
      '{8'hFF, SEC_DISCARD, 32'd0,  1'b0, 1'b1},
      '{8'h00, SEC_DISCARD, 32'd0,  1'b0, 1'b1},
      '{8'h3C, SEC_DISCARD, 32'd0,  1'b0, 1'b1}
   };

   // frame tracking state
   logic [33:0]      frame_pos = '0;
   logic [LEN_W-1:0] meta_len_q = '0;
   logic [LEN_W-1:0] msg_len_q = '0;
   logic [7:0]       len_bytes [0:7] = '{default: 8'h00};
   logic             oversize_latched = 1'b0;
   logic [LEN_W-1:0] body_limit_q = '1;

   lpfr_result_type pending_tags [$];
   int unsigned     mismatch_count = 0;
   int unsigned     beats_sent = 0;
   int unsigned     burst_left = 0;
   int unsigned     stall_run = 0;
   int unsigned     stall_mode = 0;

   task automatic classify_byte(input logic [7:0] b, output lpfr_result_type tag);
      logic [32:0] body_len;
      logic [33:0] body_pos;
      tag.data    = b;
      tag.section = SEC_HEADER;
      tag.offset  = '0;
      tag.done    = 1'b0;
      tag.err     = 1'b0;
      if (oversize_latched) begin
         tag.section = SEC_DISCARD;
         tag.err     = 1'b1;
      end else if (frame_pos < HEADER_BYTES) begin
         tag.offset = frame_pos[31:0];
         if (frame_pos >= META_LEN_FIRST && frame_pos < LEN_END)
            len_bytes[frame_pos - META_LEN_FIRST] = b;
         if (frame_pos == HEADER_BYTES - 1) begin
            meta_len_q = {len_bytes[0], len_bytes[1], len_bytes[2], len_bytes[3]};
            msg_len_q  = {len_bytes[4], len_bytes[5], len_bytes[6], len_bytes[7]};
            body_len   = {1'b0, meta_len_q} + {1'b0, msg_len_q};
            if (body_len >= {1'b0, body_limit_q}) begin
               tag.err          = 1'b1;
               oversize_latched = 1'b1;
               frame_pos        = frame_pos + 1;
            end else if (body_len == 0) begin
               tag.done  = 1'b1;
               frame_pos = '0;
            end else begin
               frame_pos = frame_pos + 1;
            end
         end else begin
            frame_pos = frame_pos + 1;
         end
      end else begin
         body_pos = frame_pos - HEADER_BYTES;
         body_len = {1'b0, meta_len_q} + {1'b0, msg_len_q};
         if (body_pos < meta_len_q) begin
            tag.section = SEC_META;
            tag.offset  = body_pos[31:0];
         end else begin
            tag.section = SEC_MESSAGE;
            tag.offset  = body_pos[31:0] - meta_len_q;
         end
         if (body_pos + 1 >= body_len) begin
            tag.done  = 1'b1;
            frame_pos = '0;
         end else begin
            frame_pos = frame_pos + 1;
         end
      end
   endtask

   // entered and left just after a falling edge
   task automatic send_beat(input logic [7:0] b, input logic typed,
                            input lpfr_result_type typed_tag);
      int unsigned     gap;
      lpfr_result_type tag;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      classify_byte(b, tag);
      pending_tags.push_back(typed ? typed_tag : tag);
      beats_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic walk_table(input int first, input int last);
      for (int i = first; i <= last; i++)
         send_beat(beat_table[i].data, 1'b1, beat_table[i]);
   endtask

   task automatic send_frame();
      logic [32:0]  max_body;
      int unsigned  body_n;
      int unsigned  meta_n;
      int unsigned  msg_n;
      int unsigned  pick;
      logic [7:0]   hdr [0:15];
      max_body = {1'b0, body_limit_q} - 1;
      if ($urandom_range(0, 15) == 0) begin
         if (max_body > 300) max_body = 300;
      end else begin
         if (max_body > 40) max_body = 40;
      end
      pick = $urandom_range(0, 9);
      if (pick < 2)
         body_n = 0;
      else if (pick == 2)
         body_n = max_body;
      else
         body_n = $urandom_range(0, max_body);
      case ($urandom_range(0, 3))
         0: meta_n = 0;
         1: meta_n = body_n;
         default: meta_n = $urandom_range(0, body_n);
      endcase
      msg_n = body_n - meta_n;
      foreach (hdr[i]) hdr[i] = $urandom_range(0, 255);
      {hdr[4], hdr[5], hdr[6], hdr[7]}   = meta_n;
      {hdr[8], hdr[9], hdr[10], hdr[11]} = msg_n;
      foreach (hdr[i]) send_beat(hdr[i], 1'b0, '0);
      repeat (body_n) send_beat($urandom_range(0, 255), 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tags.size() != 0) @(negedge clock);
   endtask

   task automatic write_body_limit(input logic [LEN_W-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      body_limit_q      = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   // receiver back-pressure, switching between modes
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_run  = $urandom_range(20, 150);
      end else begin
         stall_run--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_run[3];
      endcase
   end

   always @(posedge clock) begin
      lpfr_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_tags.size() == 0) begin
            $error("result beat with nothing expected: byte 0x%0h", rsp_byte_out);
            mismatch_count++;
         end else begin
            want = pending_tags.pop_front();
            compare_field("byte_out", want.data, rsp_byte_out);
            compare_field("section", want.section, rsp_section);
            compare_field("offset", want.offset, rsp_offset);
            compare_field("frame_done", want.done, rsp_frame_done);
            compare_field("error_code", want.err, rsp_error_code);
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [LEN_W-1:0] limit_value;
      int unsigned      phase_end;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      walk_table(0, 15);
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: limit_value = 32'hFFFF_FFFF;
            1: limit_value = $urandom_range(2, 40);
            2: limit_value = 32'd1;
            3: limit_value = 32'h8000_0000;
            4: limit_value = $urandom_range(41, 32'hFFFF_FFFF);
            default: limit_value = $urandom_range(2, 12);
         endcase
         write_body_limit(limit_value);
         phase_end = beats_sent + 250;
         while (beats_sent < phase_end) send_frame();
      end
      // zero limit rejects even an empty body; everything after is discarded
      write_body_limit(32'd0);
      walk_table(16, 34);
      wait_drained();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0 && pending_tags.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
